>>> hw/rtl/triangular_back_substitution_assert.svh
// Assertion macros shared by the checker of the triangular solver.
// No dependencies; included by the checker file.
`ifndef TRIANGULAR_BACK_SUBSTITUTION_ASSERT_SVH
`define TRIANGULAR_BACK_SUBSTITUTION_ASSERT_SVH
// Same-cycle implication, disabled while reset is low.
`define TBS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define TBS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
// Next-cycle implication that is also checked across reset.
`define TBS_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/tbs_pkg.sv
// Shared constants, types and helpers of the triangular solver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tbs_pkg;
  localparam int MAX_ORDER = 64;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int MAT_DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int MAT_AW    = 2 * IDX_W;
  localparam int VAL_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int ORD_W     = 7;
  localparam int DVD_W     = VAL_W + FRAC_W;
  localparam int CNT_W     = $clog2(DVD_W + 1);

  localparam logic [1:0] MODE_MAT   = 2'd0;
  localparam logic [1:0] MODE_VEC   = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // A zero diagonal outranks saturation and stays for the rest of the run.
  function automatic logic [1:0] raise_status(input logic [1:0] cur, input logic [1:0] code);
    logic [1:0] res;
    res = cur;
    if (cur != ST_ZERO && (code == ST_ZERO || cur == ST_OK)) begin
      res = code;
    end
    return res;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/tbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module tbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/tbs_div.sv
// Iterative signed divider: (num * 2^16) / den, truncated, saturated to 32 bits.
// Depends on tbs_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module tbs_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire tbs_pkg::val_t num,
  input  wire tbs_pkg::val_t den,
  output logic               done,
  output tbs_pkg::val_t      quot,
  output logic               sat
);
  logic [tbs_pkg::DVD_W-1:0] dvd_r, q_r;
  logic [tbs_pkg::VAL_W-1:0] rem_r, den_r;
  logic [tbs_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r, done_r, neg_r;
  logic [tbs_pkg::VAL_W:0]   trial, diff;
  logic [tbs_pkg::VAL_W-1:0] mag_n, mag_d;
  logic [tbs_pkg::DVD_W-1:0] lim;

  assign mag_n = num[tbs_pkg::VAL_W-1] ? (~num + 1'b1) : num;
  assign mag_d = den[tbs_pkg::VAL_W-1] ? (~den + 1'b1) : den;
  assign trial = {rem_r, dvd_r[tbs_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        dvd_r  <= {mag_n, {tbs_pkg::FRAC_W{1'b0}}};
        den_r  <= mag_d;
        rem_r  <= '0;
        q_r    <= '0;
        cnt_r  <= '0;
        neg_r  <= num[tbs_pkg::VAL_W-1] ^ den[tbs_pkg::VAL_W-1];
      end else if (busy_r) begin
        dvd_r <= {dvd_r[tbs_pkg::DVD_W-2:0], 1'b0};
        if (!diff[tbs_pkg::VAL_W]) begin
          rem_r <= diff[tbs_pkg::VAL_W-1:0];
          q_r   <= {q_r[tbs_pkg::DVD_W-2:0], 1'b1};
        end else begin
          rem_r <= trial[tbs_pkg::VAL_W-1:0];
          q_r   <= {q_r[tbs_pkg::DVD_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tbs_pkg::CNT_W'(tbs_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The negative range reaches one step further than the positive one.
  always_comb begin
    lim  = tbs_pkg::DVD_W'(tbs_pkg::VAL_MAX) + tbs_pkg::DVD_W'(neg_r);
    sat  = q_r > lim;
    if (neg_r) begin
      quot = sat ? tbs_pkg::VAL_MIN : tbs_pkg::val_t'(~q_r[tbs_pkg::VAL_W-1:0] + 1'b1);
    end else begin
      quot = sat ? tbs_pkg::VAL_MAX : tbs_pkg::val_t'(q_r[tbs_pkg::VAL_W-1:0]);
    end
  end

  assign done = done_r;
endmodule
`default_nettype wire

>>> hw/rtl/triangular_back_substitution.sv
// Each row reads its diagonal, divides its right-hand side by it (a zero diagonal skips the
// division and gives zero), updates every row above it through the update pipeline, waits for
// that pipeline to drain and hands over its beat, waiting while the result side stalls.
// Loads are taken one per cycle; in_stall stays high for the whole solve. Synchronous
// active-low reset clears control state and sets the order to 64; the RAMs are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module triangular_back_substitution (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [tbs_pkg::ORD_W-1:0]     cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [tbs_pkg::IDX_W-1:0]     in_row_index,
  input  wire logic [tbs_pkg::IDX_W-1:0]     in_column_index,
  input  wire logic signed [tbs_pkg::VAL_W-1:0] in_entry_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tbs_pkg::IDX_W-1:0]          out_solution_row,
  output logic signed [tbs_pkg::VAL_W-1:0]   out_solution_value,
  output logic                               out_last_of_run,
  output logic [1:0]                         out_status_code
);
  typedef enum logic [2:0] {S_IDLE, S_RDDIAG, S_WTDIAG, S_DIV, S_UPD, S_EMIT} state_t;
  state_t state_r;

  logic [tbs_pkg::ORD_W-1:0] order_r;
  logic [tbs_pkg::IDX_W-1:0] i_r, j_r, j1_r, j2_r, last_row;
  logic [1:0]                status_r;
  tbs_pkg::val_t             x_r, b2_r;
  logic signed [2*tbs_pkg::VAL_W-1:0] prod_r;
  logic                      v1_r, v2_r;

  logic                      in_acc;
  logic                      mat_we, vec_we, rd_en;
  logic [tbs_pkg::MAT_AW-1:0] mat_raddr;
  logic [tbs_pkg::IDX_W-1:0] vec_raddr, vec_waddr;
  tbs_pkg::val_t             vec_wdata, mat_rdata, vec_rdata;
  logic                      div_start, div_done, div_sat;
  tbs_pkg::val_t             div_quot;

  logic signed [2*tbs_pkg::VAL_W-1:0] scaled;
  logic                      p_sat, d_sat;
  tbs_pkg::val_t             p_cl, d_cl;
  logic signed [tbs_pkg::VAL_W:0] d_full;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // Order clamped into 1..MAX_ORDER, expressed as the index of the last row.
  always_comb begin
    if (order_r == '0) begin
      last_row = '0;
    end else if (order_r > tbs_pkg::ORD_W'(tbs_pkg::MAX_ORDER)) begin
      last_row = tbs_pkg::IDX_W'(tbs_pkg::MAX_ORDER - 1);
    end else begin
      last_row = tbs_pkg::IDX_W'(order_r - 1'b1);
    end
  end

  // Second update stage: floor-scaled product, then the saturating difference.
  always_comb begin
    scaled = prod_r >>> tbs_pkg::FRAC_W;
    p_sat  = (scaled > (2*tbs_pkg::VAL_W)'(tbs_pkg::VAL_MAX)) ||
             (scaled < (2*tbs_pkg::VAL_W)'(tbs_pkg::VAL_MIN));
    if (scaled > (2*tbs_pkg::VAL_W)'(tbs_pkg::VAL_MAX)) begin
      p_cl = tbs_pkg::VAL_MAX;
    end else if (scaled < (2*tbs_pkg::VAL_W)'(tbs_pkg::VAL_MIN)) begin
      p_cl = tbs_pkg::VAL_MIN;
    end else begin
      p_cl = tbs_pkg::val_t'(scaled[tbs_pkg::VAL_W-1:0]);
    end
    d_full = {b2_r[tbs_pkg::VAL_W-1], b2_r} - {p_cl[tbs_pkg::VAL_W-1], p_cl};
    d_sat  = d_full[tbs_pkg::VAL_W] != d_full[tbs_pkg::VAL_W-1];
    if (d_sat) begin
      d_cl = d_full[tbs_pkg::VAL_W] ? tbs_pkg::VAL_MIN : tbs_pkg::VAL_MAX;
    end else begin
      d_cl = tbs_pkg::val_t'(d_full[tbs_pkg::VAL_W-1:0]);
    end
  end

  always_comb begin
    mat_we    = in_acc && (in_mode == tbs_pkg::MODE_MAT);
    vec_we    = 1'b0;
    vec_waddr = in_row_index;
    vec_wdata = in_entry_value;
    rd_en     = 1'b0;
    mat_raddr = {i_r, i_r};
    vec_raddr = i_r;
    div_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        vec_we = in_acc && (in_mode == tbs_pkg::MODE_VEC);
      end
      S_RDDIAG: begin
        rd_en = 1'b1;
      end
      S_WTDIAG: begin
        vec_waddr = i_r;
        vec_wdata = '0;
        if (mat_rdata == '0) begin
          vec_we = 1'b1;
        end else begin
          div_start = 1'b1;
        end
      end
      S_DIV: begin
        vec_waddr = i_r;
        vec_wdata = div_quot;
        vec_we    = div_done;
      end
      S_UPD: begin
        rd_en     = (j_r != i_r);
        mat_raddr = {j_r, i_r};
        vec_raddr = j_r;
        vec_waddr = j2_r;
        vec_wdata = d_cl;
        vec_we    = v2_r;
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      order_r   <= tbs_pkg::ORD_W'(tbs_pkg::MAX_ORDER);
      status_r  <= tbs_pkg::ST_OK;
      out_valid <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        order_r <= cfg_wr_data;
      end
      // In S_EMIT the valid flag is handled by the state itself.
      if (out_valid && !out_stall && state_r != S_EMIT) begin
        out_valid <= 1'b0;
      end
      v1_r <= (state_r == S_UPD) && (j_r != i_r);
      v2_r <= v1_r;
      j1_r <= j_r;
      j2_r <= j1_r;
      b2_r <= vec_rdata;
      prod_r <= x_r * mat_rdata;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_mode == tbs_pkg::MODE_START) begin
            status_r <= tbs_pkg::ST_OK;
            i_r      <= last_row;
            state_r  <= S_RDDIAG;
          end
        end
        S_RDDIAG: begin
          state_r <= S_WTDIAG;
        end
        S_WTDIAG: begin
          j_r <= '0;
          if (mat_rdata == '0) begin
            x_r      <= '0;
            status_r <= tbs_pkg::raise_status(status_r, tbs_pkg::ST_ZERO);
            state_r  <= S_UPD;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            x_r <= div_quot;
            if (div_sat) begin
              status_r <= tbs_pkg::raise_status(status_r, tbs_pkg::ST_SAT);
            end
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (j_r != i_r) begin
            j_r <= j_r + 1'b1;
          end
          if (v2_r && (p_sat || d_sat)) begin
            status_r <= tbs_pkg::raise_status(status_r, tbs_pkg::ST_SAT);
          end
          if (j_r == i_r && !v1_r && !v2_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_solution_row   <= i_r;
            out_solution_value <= x_r;
            out_last_of_run    <= (i_r == '0);
            out_status_code    <= status_r;
            if (i_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r - 1'b1;
              state_r <= S_RDDIAG;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  tbs_ram #(.WIDTH(tbs_pkg::VAL_W), .DEPTH(tbs_pkg::MAT_DEPTH)) u_mat_ram (
    .clk   (clk),
    .we    (mat_we),
    .waddr ({in_row_index, in_column_index}),
    .wdata (in_entry_value),
    .re    (rd_en),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  tbs_ram #(.WIDTH(tbs_pkg::VAL_W), .DEPTH(tbs_pkg::MAX_ORDER)) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (vec_wdata),
    .re    (rd_en),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  tbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (vec_rdata),
    .den   (mat_rdata),
    .done  (div_done),
    .quot  (div_quot),
    .sat   (div_sat)
  );
endmodule
`default_nettype wire

>>> hw/rtl/tbs_checker.sv
// Port-level checker of the triangular solver, bound to the top level.
// Depends on tbs_pkg and triangular_back_substitution_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "triangular_back_substitution_assert.svh"
module tbs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic signed [tbs_pkg::VAL_W-1:0] out_solution_value,
  input wire logic                        out_last_of_run,
  input wire logic [1:0]                  out_status_code
);
  // A stalled result beat holds its value.
  `TBS_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_solution_value))
  `TBS_ASSERT_IMP(a_code, clk, rst_n, out_valid, out_status_code != 2'd3)
  // More rows remain after a beat that is not the last, so no load is taken.
  `TBS_ASSERT_IMP(a_busy, clk, rst_n, out_valid && !out_last_of_run, in_stall)
  `TBS_ASSERT_RST(a_rst, clk, !rst_n, !out_valid && !in_stall)
endmodule

bind triangular_back_substitution tbs_checker u_tbs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_solution_value (out_solution_value),
  .out_last_of_run    (out_last_of_run),
  .out_status_code    (out_status_code)
);
`default_nettype wire

>>> sim/triangular_back_substitution_test.sv
// Self-checking testbench for the upper triangular back-substitution solver.
// Depends on tbs_pkg and triangular_back_substitution; predicts each solve in Q16.16.
`timescale 1ns / 1ps
module triangular_back_substitution_test;
  import tbs_pkg::*;

  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam int         STALL_GAP  = 20000;
  localparam int         HOLD_LEN   = 300;
  localparam int         SETTLE     = 40;

  typedef struct {
    logic [IDX_W-1:0] row;
    val_t             value;
    logic             last;
    logic [1:0]       status;
  } solution_t;

  typedef struct {
    logic [1:0]       mode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    val_t             value;
    bit               typed;
    val_t             x_value;
    logic [1:0]       x_status;
  } stim_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [ORD_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_mode = MODE_NONE;
  logic [IDX_W-1:0]     in_row_index = '0;
  logic [IDX_W-1:0]     in_column_index = '0;
  val_t                 in_entry_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [IDX_W-1:0]     out_solution_row;
  val_t                 out_solution_value;
  logic                 out_last_of_run;
  logic [1:0]           out_status_code;

  triangular_back_substitution uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_mode(in_mode),
    .in_row_index(in_row_index), .in_column_index(in_column_index),
    .in_entry_value(in_entry_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_solution_row(out_solution_row), .out_solution_value(out_solution_value),
    .out_last_of_run(out_last_of_run), .out_status_code(out_status_code)
  );

  // Shadow copy of the solver state.
  longint    coef[MAX_ORDER][MAX_ORDER];
  longint    rhs[MAX_ORDER];
  bit        coef_ok[MAX_ORDER][MAX_ORDER];
  bit        rhs_ok[MAX_ORDER];
  int        order_reg = 64;
  solution_t expected_x[$];

  int  fail_count = 0;
  int  idle_run = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clip(input longint v, inout bit hit);
    if (v > longint'(VAL_MAX)) begin
      hit = 1'b1;
      return longint'(VAL_MAX);
    end
    if (v < longint'(VAL_MIN)) begin
      hit = 1'b1;
      return longint'(VAL_MIN);
    end
    return v;
  endfunction

  function automatic logic [1:0] bump_status(input logic [1:0] st, input logic [1:0] code);
    if (st == ST_ZERO) return st;
    if (code == ST_ZERO || st == ST_OK) return code;
    return st;
  endfunction

  // Runs the backward substitution on the shadow stores, queueing one beat per row.
  function automatic void predict_solve();
    int         n;
    int         i;
    longint     x;
    longint     p;
    bit         sat;
    logic [1:0] st;
    solution_t  s;
    n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : order_reg);
    st = ST_OK;
    for (int k = n; k > 0; k--) begin
      i = k - 1;
      if (coef[i][i] == 0) begin
        x = 0;
        st = bump_status(st, ST_ZERO);
      end else begin
        sat = 1'b0;
        x = clip((rhs[i] * 65536) / coef[i][i], sat);
        if (sat) st = bump_status(st, ST_SAT);
      end
      rhs[i] = x;
      for (int j = 0; j < i; j++) begin
        sat = 1'b0;
        p = clip((x * coef[j][i]) >>> FRAC_W, sat);
        rhs[j] = clip(rhs[j] - p, sat);
        if (sat) st = bump_status(st, ST_SAT);
      end
      s.row = IDX_W'(i);
      s.value = x[VAL_W-1:0];
      s.last = (i == 0);
      s.status = st;
      expected_x.push_back(s);
    end
  endfunction

  function automatic void absorb_beat(input logic [1:0] m, input int r, input int c,
                                      input val_t v);
    case (m)
      MODE_MAT: begin
        coef[r][c] = longint'(v);
        coef_ok[r][c] = 1'b1;
      end
      MODE_VEC: begin
        rhs[r] = longint'(v);
        rhs_ok[r] = 1'b1;
      end
      MODE_START: predict_solve();
      default: ;
    endcase
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // Presents one beat and returns at the edge that accepts it.
  task automatic send_beat(input logic [1:0] m, input int r, input int c, input val_t v);
    bit taken;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_row_index <= r[IDX_W-1:0];
    in_column_index <= c[IDX_W-1:0];
    in_entry_value <= v;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    absorb_beat(m, r, c, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_x.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_order(input int ord);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= ord[ORD_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_reg = ord;
  endtask

  function automatic val_t pick_value(input bit diag);
    int sel;
    sel = $urandom_range(0, 11);
    if (diag && sel == 0) return '0;
    if (diag && sel < 6) return val_t'($urandom_range(32768, 262144)) * ($urandom_range(0, 1) ? 1 : -1);
    case (sel)
      0, 1: return '0;
      2: return VAL_MAX;
      3: return VAL_MIN;
      4, 5, 6: return val_t'($urandom);
      default: return val_t'($urandom_range(0, 524288)) - val_t'(262144);
    endcase
  endfunction

  // Loads every entry the next solve reads that has not been written yet.
  task automatic fill_missing();
    int n;
    n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : order_reg);
    for (int i = 0; i < n; i++) begin
      if (!rhs_ok[i]) send_beat(MODE_VEC, i, $urandom_range(0, 63), pick_value(1'b0));
      for (int j = 0; j <= i; j++) begin
        if (!coef_ok[j][i]) send_beat(MODE_MAT, j, i, pick_value(i == j));
      end
    end
  endtask

  task automatic random_round();
    int n;
    int r;
    int c;
    n = (order_reg == 0) ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : order_reg);
    repeat ($urandom_range(2, 8)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          c = $urandom_range(0, n - 1);
          r = $urandom_range(0, c);
          send_beat(MODE_MAT, r, c, pick_value(r == c));
        end
        6: send_beat(MODE_VEC, $urandom_range(0, n - 1), $urandom_range(0, 63),
                     pick_value(1'b0));
        7: send_beat(MODE_MAT, $urandom_range(0, 63), $urandom_range(0, 63),
                     pick_value(1'b0));
        8: send_beat(MODE_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                     val_t'($urandom));
        default: send_beat(MODE_VEC, $urandom_range(0, 63), $urandom_range(0, 63),
                           pick_value(1'b0));
      endcase
    end
    fill_missing();
    send_beat(MODE_START, $urandom_range(0, 63), $urandom_range(0, 63), val_t'($urandom));
  endtask

  stim_t directed[] = '{
    '{MODE_MAT,   6'd0,  6'd0,  32'h00010000, 1'b0, '0, ST_OK},
    '{MODE_VEC,   6'd0,  6'd63, VAL_MAX,      1'b0, '0, ST_OK},
    '{MODE_START, 6'd0,  6'd0,  '0,           1'b1, VAL_MAX, ST_OK},
    '{MODE_MAT,   6'd0,  6'd0,  '0,           1'b0, '0, ST_OK},
    '{MODE_START, 6'd63, 6'd63, 32'hffffffff, 1'b1, '0, ST_ZERO},
    '{MODE_VEC,   6'd0,  6'd0,  VAL_MIN,      1'b0, '0, ST_OK},
    '{MODE_MAT,   6'd0,  6'd0,  32'h00000001, 1'b0, '0, ST_OK},
    '{MODE_START, 6'd0,  6'd0,  '0,           1'b1, VAL_MIN, ST_SAT},
    '{MODE_MAT,   6'd0,  6'd0,  32'hffff0000, 1'b0, '0, ST_OK},
    '{MODE_START, 6'd0,  6'd0,  '0,           1'b1, VAL_MAX, ST_SAT},
    '{MODE_NONE,  6'd63, 6'd63, 32'hffffffff, 1'b0, '0, ST_OK},
    '{MODE_MAT,   6'd63, 6'd63, VAL_MIN,      1'b0, '0, ST_OK},
    '{MODE_MAT,   6'd63, 6'd0,  VAL_MAX,      1'b0, '0, ST_OK},
    '{MODE_VEC,   6'd63, 6'd0,  32'h0000ffff, 1'b0, '0, ST_OK},
    '{MODE_MAT,   6'd0,  6'd0,  32'h00020000, 1'b0, '0, ST_OK},
    '{MODE_VEC,   6'd0,  6'd0,  32'hfffc0000, 1'b0, '0, ST_OK},
    '{MODE_START, 6'd0,  6'd0,  '0,           1'b1, 32'hfffe0000, ST_OK}
  };

  int order_plan[] = '{2, 5, 0, 3, 8, 4, 1, 6};

  initial begin
    solution_t s;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_order(1);
    foreach (directed[k]) begin
      send_beat(directed[k].mode, directed[k].row, directed[k].col, directed[k].value);
      if (directed[k].typed) begin
        void'(expected_x.pop_back());
        s.row = '0;
        s.value = directed[k].x_value;
        s.last = 1'b1;
        s.status = directed[k].x_status;
        expected_x.push_back(s);
      end
    end
    foreach (order_plan[p]) begin
      drain();
      set_order(order_plan[p]);
      if (p == 1) hold_req = 1'b1;
      if (p == order_plan.size() - 1) quiet = 1'b1;
      repeat ((p == 1) ? 2 : 1) random_round();
    end
    drain();
    if (fail_count == 0) begin
      $display("triangular_back_substitution regression: pass");
    end else begin
      $display("triangular_back_substitution regression: fail");
    end
    $finish;
  end

  // Result side back-pressure, with one long hold-off while the sender keeps offering.
  initial begin
    forever begin
      if (!rst_n || quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // Everything is stable at the falling edge, so the beat seen here lands at the next rise.
  always @(negedge clk) begin
    solution_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_x.size() == 0) begin
        flag_error($sformatf("unexpected beat row %0d", out_solution_row));
      end else begin
        e = expected_x.pop_front();
        if (out_solution_row !== e.row)
          flag_error($sformatf("row %0d, expected %0d", out_solution_row, e.row));
        if (out_solution_value !== e.value)
          flag_error($sformatf("row %0d value %h, expected %h", e.row, out_solution_value,
                               e.value));
        if (out_last_of_run !== e.last)
          flag_error($sformatf("row %0d last %b, expected %b", e.row, out_last_of_run, e.last));
        if (out_status_code !== e.status)
          flag_error($sformatf("row %0d status %0d, expected %0d", e.row, out_status_code,
                               e.status));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
    end
    if (idle_run >= STALL_GAP) begin
      $display("triangular_back_substitution regression: fail");
      $finish;
    end
  end
endmodule
